FILE: src/qat_pkg.sv
// shared constants and result type for the quote-aware tokenizer
`default_nettype none

package qat_pkg;

  // byte codes with a special meaning
  localparam logic [7:0] QUOTE_SINGLE = 8'h27;
  localparam logic [7:0] QUOTE_DOUBLE = 8'h22;
  localparam logic [7:0] BACKSLASH    = 8'h5C;

  // delimiter register layout
  localparam int unsigned CFG_WIDTH = 32;
  localparam int unsigned CFG_SLOTS = CFG_WIDTH / 8;
  localparam logic [CFG_WIDTH-1:0] DELIM_RESET = 32'h0A09_2C20;

  // leading quote of the current token
  localparam logic [1:0] LEAD_NONE   = 2'd0;
  localparam logic [1:0] LEAD_SINGLE = 2'd1;
  localparam logic [1:0] LEAD_DOUBLE = 2'd2;

  // one result without its count
  typedef struct packed {
    logic       config_error;
    logic       ends_string;
    logic       ends_token;
    logic       has_byte;
    logic [7:0] out_byte;
  } res_t;

endpackage

`default_nettype wire

FILE: src/quote_aware_tokenizer_top.sv
// quote-aware tokenizer: byte stream in, token bytes and marks out
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata[7:0] in_byte, tlast end_of_string
//  m_axis    out  m_axis_tvalid/tready      tdata out_byte, token_count; tlast ends_string;
//                                           tuser has_byte, ends_token, config_error
//  cfg       in   cfg_we_i                  cfg_wdata_i delimiter set
//
// one byte is taken per cycle while the buffer has room; the scan state updates in the cycle of the request,
// and a result enters a two-entry output buffer, whose head entry drives m_axis.
// s_axis_tready drops only while both buffer entries are full.
// rst_ni clears the scan state, the count, the buffer and loads the default
// delimiter set (space, comma, tab, newline).
`default_nettype none

module quote_aware_tokenizer_top
  import qat_pkg::*;
#(
  parameter int unsigned DELIMITER_SLOTS = 4,
  parameter int unsigned COUNT_WIDTH     = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // tdata: [7:0] in_byte
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,
  input  wire logic                 s_axis_tlast,
  // tdata: [7:0] out_byte, then token_count, zero filled to whole bytes
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [((8+COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,
  // tuser: [0] has_byte, [1] ends_token, [2] config_error
  output logic [2:0]                m_axis_tuser,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_WIDTH-1:0] cfg_wdata_i
);

  localparam int unsigned USED_SLOTS =
      (DELIMITER_SLOTS < CFG_SLOTS) ? DELIMITER_SLOTS : CFG_SLOTS;
  localparam int unsigned TDATA_W = ((8 + COUNT_WIDTH + 7) / 8) * 8;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    MODE_BETWEEN,
    MODE_TOKEN,
    MODE_QUOTED
  } mode_e;

  // scan state
  logic [CFG_WIDTH-1:0]   delim_q;
  mode_e                  mode_q, mode_d;
  logic                   dq_open_q, dq_open_d;
  logic                   prev_bs_q, prev_bs_d;
  logic [1:0]             lead_q, lead_d;
  logic [7:0]             held_q, held_d;
  logic                   held_vld_q, held_vld_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

  // output buffer
  res_t                   slot_res_q [2];
  logic [COUNT_WIDTH-1:0] slot_cnt_q [2];
  logic [1:0]             fill_q;

  logic                   accept, pop, push;
  res_t                   res;
  logic [COUNT_WIDTH-1:0] res_cnt, cnt_inc;
  logic [7:0]             in_b;
  logic                   eos;
  logic                   b_delim, sq_delim, dq_delim, any_delim;
  logic                   quote_in_set, b_quote, final_has;
  logic [7:0]             lead_byte;

  assign in_b   = s_axis_tdata;
  assign eos    = s_axis_tlast;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;

  // delimiter matching against the used slots
  always_comb begin
    b_delim   = 1'b0;
    sq_delim  = 1'b0;
    dq_delim  = 1'b0;
    any_delim = 1'b0;
    for (int i = 0; i < USED_SLOTS; i++) begin
      if (delim_q[8*i +: 8] != 8'h00) begin
        any_delim = 1'b1;
        if (delim_q[8*i +: 8] == in_b)         b_delim  = 1'b1;
        if (delim_q[8*i +: 8] == QUOTE_SINGLE) sq_delim = 1'b1;
        if (delim_q[8*i +: 8] == QUOTE_DOUBLE) dq_delim = 1'b1;
      end
    end
  end

  assign quote_in_set = sq_delim || dq_delim;
  assign b_quote      = (in_b == QUOTE_SINGLE) || (in_b == QUOTE_DOUBLE);
  assign cnt_inc      = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;

  // last held byte is dropped when it repeats the leading quote
  assign lead_byte = (lead_q == LEAD_DOUBLE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
  assign final_has = held_vld_q && ((lead_q == LEAD_NONE) || (held_q != lead_byte));

  // one scan step per accepted byte
  always_comb begin
    mode_d     = mode_q;
    dq_open_d  = dq_open_q;
    prev_bs_d  = prev_bs_q;
    lead_d     = lead_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    cnt_d      = cnt_q;
    push       = 1'b0;
    res        = '0;
    res_cnt    = cnt_q;

    if (quote_in_set) begin
      mode_d     = MODE_BETWEEN;
      dq_open_d  = 1'b0;
      prev_bs_d  = 1'b0;
      lead_d     = LEAD_NONE;
      held_d     = 8'h00;
      held_vld_d = 1'b0;
      cnt_d      = '0;
      if (eos) begin
        push             = 1'b1;
        res.ends_string  = 1'b1;
        res.config_error = 1'b1;
        res_cnt          = '0;
      end
    end else if (eos) begin
      push            = 1'b1;
      res.ends_string = 1'b1;
      if (mode_q != MODE_BETWEEN) begin
        res.has_byte   = final_has;
        res.out_byte   = final_has ? held_q : 8'h00;
        res.ends_token = 1'b1;
        res_cnt        = cnt_inc;
      end else if (!any_delim && (cnt_q == '0)) begin
        res.ends_token = 1'b1;
        res_cnt        = cnt_inc;
      end
      mode_d     = MODE_BETWEEN;
      dq_open_d  = 1'b0;
      prev_bs_d  = 1'b0;
      lead_d     = LEAD_NONE;
      held_d     = 8'h00;
      held_vld_d = 1'b0;
      cnt_d      = '0;
    end else if (mode_q == MODE_BETWEEN) begin
      // first byte of a token, delimiters skipped
      if (!b_delim) begin
        mode_d    = MODE_TOKEN;
        prev_bs_d = (in_b == BACKSLASH);
        if (b_quote) begin
          lead_d    = (in_b == QUOTE_DOUBLE) ? LEAD_DOUBLE : LEAD_SINGLE;
          dq_open_d = (in_b == QUOTE_DOUBLE);
          mode_d    = MODE_QUOTED;
        end else begin
          held_d     = in_b;
          held_vld_d = 1'b1;
        end
      end
    end else if ((mode_q == MODE_TOKEN) && b_delim) begin
      // delimiter closes the token
      push           = 1'b1;
      res.has_byte   = final_has;
      res.out_byte   = final_has ? held_q : 8'h00;
      res.ends_token = 1'b1;
      res_cnt        = cnt_inc;
      cnt_d          = cnt_inc;
      mode_d         = MODE_BETWEEN;
      dq_open_d      = 1'b0;
      prev_bs_d      = 1'b0;
      lead_d         = LEAD_NONE;
      held_d         = 8'h00;
      held_vld_d     = 1'b0;
    end else begin
      // token byte: release the held one, hold the new one
      if (held_vld_q) begin
        push         = 1'b1;
        res.has_byte = 1'b1;
        res.out_byte = held_q;
      end
      held_d     = in_b;
      held_vld_d = 1'b1;
      if (!prev_bs_q && b_quote) begin
        if (mode_q == MODE_TOKEN) begin
          mode_d    = MODE_QUOTED;
          dq_open_d = (in_b == QUOTE_DOUBLE);
        end else if ((in_b == QUOTE_DOUBLE) == dq_open_q) begin
          mode_d = MODE_TOKEN;
        end
      end
      prev_bs_d = (in_b == BACKSLASH);
    end
  end

  // delimiter register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
    end else if (cfg_we_i) begin
      delim_q <= cfg_wdata_i;
    end
  end

  // scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_BETWEEN;
      dq_open_q  <= 1'b0;
      prev_bs_q  <= 1'b0;
      lead_q     <= LEAD_NONE;
      held_q     <= 8'h00;
      held_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else if (accept) begin
      mode_q     <= mode_d;
      dq_open_q  <= dq_open_d;
      prev_bs_q  <= prev_bs_d;
      lead_q     <= lead_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      cnt_q      <= cnt_d;
    end
  end

  // two-entry output buffer, entry 0 is the head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else begin
      case ({accept && push, pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case ({accept && push, pop})
      2'b10: begin
        if (fill_q == 2'd0) begin
          slot_res_q[0] <= res;
          slot_cnt_q[0] <= res_cnt;
        end else begin
          slot_res_q[1] <= res;
          slot_cnt_q[1] <= res_cnt;
        end
      end
      2'b01: begin
        slot_res_q[0] <= slot_res_q[1];
        slot_cnt_q[0] <= slot_cnt_q[1];
      end
      2'b11: begin
        if (fill_q == 2'd1) begin
          slot_res_q[0] <= res;
          slot_cnt_q[0] <= res_cnt;
        end else begin
          slot_res_q[0] <= slot_res_q[1];
          slot_cnt_q[0] <= slot_cnt_q[1];
          slot_res_q[1] <= res;
          slot_cnt_q[1] <= res_cnt;
        end
      end
      default: begin
      end
    endcase
  end

  // ports
  assign s_axis_tready = (fill_q != 2'd2);
  assign m_axis_tvalid = (fill_q != 2'd0);
  assign m_axis_tlast  = slot_res_q[0].ends_string;
  assign m_axis_tuser  = {slot_res_q[0].config_error, slot_res_q[0].ends_token,
                          slot_res_q[0].has_byte};
  assign m_axis_tdata  = TDATA_W'({slot_cnt_q[0], slot_res_q[0].out_byte});

endmodule

`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench for the quote-aware tokenizer top level
`timescale 1ns / 1ps

module tb;
  import qat_pkg::*;

  localparam int unsigned SLOTS        = 4;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned TDATA_W      = ((8 + CNT_W + 7) / 8) * 8;
  localparam int unsigned PHASE_BYTES  = 56;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam longint      CYCLE_LIMIT  = 100_000;

  // scan position of the local tokenizer copy
  typedef enum logic [1:0] {
    SCAN_BETWEEN,
    SCAN_TOKEN,
    SCAN_QUOTED
  } scan_mode_e;

  // one byte request: in_byte and end_of_string
  typedef struct packed {
    logic [7:0] in_byte;
    logic       eos;
  } byte_req_t;

  // one token result with its count
  typedef struct packed {
    logic             has_byte;
    logic [7:0]       out_byte;
    logic             ends_token;
    logic             ends_string;
    logic [CNT_W-1:0] token_count;
    logic             config_error;
  } token_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;
  logic [2:0]         m_axis_tuser;
  logic               cfg_we_i      = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_wdata_i = '0;

  quote_aware_tokenizer_top #(
    .DELIMITER_SLOTS(SLOTS),
    .COUNT_WIDTH    (CNT_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  byte_req_t  bytes_to_send[$];
  token_res_t tokens_due[$];

  // local tokenizer state
  logic [CFG_WIDTH-1:0] delim_set   = DELIM_RESET;
  scan_mode_e           scan_mode   = SCAN_BETWEEN;
  logic                 open_dq     = 1'b0;
  logic                 after_bslash = 1'b0;
  logic [1:0]           lead_kind   = LEAD_NONE;
  logic [7:0]           held_byte   = '0;
  logic                 held_ok     = 1'b0;
  logic [CNT_W-1:0]     tok_count   = '0;

  // run bookkeeping
  longint cycle_count   = 0;
  int     fault_count   = 0;
  int     bytes_taken   = 0;
  int     results_seen  = 0;
  int     settings_used = 1;
  logic [CFG_WIDTH-1:0] gen_set = DELIM_RESET;

  function automatic bit is_delim(logic [CFG_WIDTH-1:0] set, logic [7:0] b);
    for (int i = 0; i < SLOTS; i++) begin
      if (set[8*i +: 8] != 8'h00 && set[8*i +: 8] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_quote(logic [7:0] b);
    return b == QUOTE_SINGLE || b == QUOTE_DOUBLE;
  endfunction

  function automatic void clear_token();
    scan_mode    = SCAN_BETWEEN;
    open_dq      = 1'b0;
    after_bslash = 1'b0;
    lead_kind    = LEAD_NONE;
    held_byte    = '0;
    held_ok      = 1'b0;
  endfunction

  function automatic void bump_count();
    if (tok_count != {CNT_W{1'b1}}) tok_count = tok_count + 1'b1;
  endfunction

  // the held byte survives a token end unless it repeats the leading quote
  function automatic bit keep_last();
    if (!held_ok) return 1'b0;
    if (lead_kind == LEAD_NONE) return 1'b1;
    return held_byte != ((lead_kind == LEAD_DOUBLE) ? QUOTE_DOUBLE : QUOTE_SINGLE);
  endfunction

  // advance the tokenizer by one byte request and report the result, if any
  function automatic void scan_byte(input logic [7:0] b, input logic eos,
                                    output bit got, output token_res_t r);
    got = 1'b0;
    r   = '0;
    // a quote among the delimiters spoils the whole string
    if (is_delim(delim_set, QUOTE_SINGLE) || is_delim(delim_set, QUOTE_DOUBLE)) begin
      clear_token();
      tok_count = '0;
      if (eos) begin
        got            = 1'b1;
        r.ends_string  = 1'b1;
        r.config_error = 1'b1;
      end
      return;
    end
    // end of string closes any open token
    if (eos) begin
      got           = 1'b1;
      r.ends_string = 1'b1;
      if (scan_mode != SCAN_BETWEEN) begin
        r.has_byte   = keep_last();
        r.out_byte   = r.has_byte ? held_byte : 8'h00;
        r.ends_token = 1'b1;
        bump_count();
      end else if (delim_set == '0 && tok_count == '0) begin
        r.ends_token = 1'b1;
        bump_count();
      end
      r.token_count = tok_count;
      clear_token();
      tok_count = '0;
      return;
    end
    // first byte of a token, leading delimiters skipped
    if (scan_mode == SCAN_BETWEEN) begin
      if (is_delim(delim_set, b)) return;
      scan_mode    = SCAN_TOKEN;
      after_bslash = (b == BACKSLASH);
      if (is_quote(b)) begin
        lead_kind = (b == QUOTE_DOUBLE) ? LEAD_DOUBLE : LEAD_SINGLE;
        open_dq   = (b == QUOTE_DOUBLE);
        scan_mode = SCAN_QUOTED;
      end else begin
        held_byte = b;
        held_ok   = 1'b1;
      end
      return;
    end
    // unquoted delimiter ends the token
    if (scan_mode == SCAN_TOKEN && is_delim(delim_set, b)) begin
      got          = 1'b1;
      r.has_byte   = keep_last();
      r.out_byte   = r.has_byte ? held_byte : 8'h00;
      r.ends_token = 1'b1;
      bump_count();
      r.token_count = tok_count;
      clear_token();
      return;
    end
    // release the held byte and hold this one
    if (held_ok) begin
      got           = 1'b1;
      r.has_byte    = 1'b1;
      r.out_byte    = held_byte;
      r.token_count = tok_count;
    end
    held_byte = b;
    held_ok   = 1'b1;
    // unescaped quotes open and close regions
    if (!after_bslash && is_quote(b)) begin
      if (scan_mode == SCAN_TOKEN) begin
        scan_mode = SCAN_QUOTED;
        open_dq   = (b == QUOTE_DOUBLE);
      end else if ((b == QUOTE_DOUBLE) == open_dq) begin
        scan_mode = SCAN_TOKEN;
      end
    end
    after_bslash = (b == BACKSLASH);
  endfunction

  // byte sender: bursts of random length, random gaps in between
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    byte_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (bytes_to_send.size() != 0) begin
        nxt = bytes_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.in_byte;
        s_axis_tlast  <= nxt.eos;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: stall pattern switches between a few modes
  int stall_mode = 0;
  int mode_left  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode    <= 0;
      mode_left     <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= cycle_count[2];
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endfunction

  // predict on each accepted request, compare each accepted result
  always @(posedge clk_i) begin
    bit         got;
    token_res_t res;
    token_res_t due;
    if (rst_ni) begin
      if (cfg_we_i) delim_set = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        scan_byte(s_axis_tdata, s_axis_tlast, got, res);
        bytes_taken++;
        if (got) tokens_due.push_back(res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (tokens_due.size() == 0) begin
          $error("unexpected result: tdata %0h tuser %0h tlast %0b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fault_count++;
        end else begin
          due = tokens_due.pop_front();
          check_field("has_byte", due.has_byte, m_axis_tuser[0]);
          check_field("out_byte", due.out_byte, m_axis_tdata[7:0]);
          check_field("ends_token", due.ends_token, m_axis_tuser[1]);
          check_field("ends_string", due.ends_string, m_axis_tlast);
          check_field("token_count", due.token_count, m_axis_tdata[8 +: CNT_W]);
          check_field("config_error", due.config_error, m_axis_tuser[2]);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, tokens_due.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] b);
    bytes_to_send.push_back('{in_byte: b, eos: 1'b0});
  endtask

  task automatic push_end();
    bytes_to_send.push_back('{in_byte: 8'($urandom_range(0, 255)), eos: 1'b1});
  endtask

  // some live delimiter of the set, or a space when the set is empty
  function automatic logic [7:0] delim_of(logic [CFG_WIDTH-1:0] set);
    int k;
    k = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (set[8*((k + i) % SLOTS) +: 8] != 8'h00) return set[8*((k + i) % SLOTS) +: 8];
    end
    return 8'h20;
  endfunction

  function automatic logic [7:0] noise_byte(logic [CFG_WIDTH-1:0] set);
    case ($urandom_range(0, 11))
      0, 1, 2: return delim_of(set);
      3:       return QUOTE_SINGLE;
      4:       return QUOTE_DOUBLE;
      5:       return BACKSLASH;
      6, 7:    return 8'($urandom_range(0, 255));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // words, some in quotes, with escapes and delimiters inside the quotes
  task automatic add_phrase(logic [CFG_WIDTH-1:0] set);
    logic [7:0] q;
    repeat ($urandom_range(1, 5)) begin
      repeat ($urandom_range(0, 2)) push_byte(delim_of(set));
      q = 8'h00;
      if ($urandom_range(0, 1)) q = $urandom_range(0, 1) ? QUOTE_SINGLE : QUOTE_DOUBLE;
      if (q != 8'h00) push_byte(q);
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0: begin
            push_byte(BACKSLASH);
            push_byte($urandom_range(0, 1) ? QUOTE_SINGLE : QUOTE_DOUBLE);
          end
          1:       push_byte(delim_of(set));
          2:       push_byte(8'($urandom_range(0, 255)));
          default: push_byte(8'h61 + 8'($urandom_range(0, 25)));
        endcase
      end
      if (q != 8'h00 && $urandom_range(0, 7) != 0) push_byte(q);
      push_byte(delim_of(set));
    end
  endtask

  // one setting: mostly phrases, some noise, sometimes left open at the end
  task automatic fill_phase(logic [CFG_WIDTH-1:0] set);
    int start;
    start = bytes_to_send.size();
    while (bytes_to_send.size() - start < PHASE_BYTES) begin
      if ($urandom_range(0, 3) != 0) begin
        add_phrase(set);
      end else begin
        repeat ($urandom_range(0, 10)) push_byte(noise_byte(set));
      end
      if (bytes_to_send.size() - start < PHASE_BYTES || $urandom_range(0, 2) != 0) push_end();
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (bytes_to_send.size() != 0 || s_axis_tvalid || tokens_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_delims(logic [CFG_WIDTH-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    gen_set = v;
    settings_used++;
  endtask

  function automatic logic [CFG_WIDTH-1:0] random_set();
    logic [CFG_WIDTH-1:0] v;
    v = $urandom();
    for (int i = 0; i < SLOTS; i++) begin
      if (is_quote(v[8*i +: 8])) v[8*i +: 8] = 8'h2D;
      if ($urandom_range(0, 3) == 0) v[8*i +: 8] = 8'h00;
    end
    return v;
  endfunction

  // stimulus
  initial begin
    logic [CFG_WIDTH-1:0] plan[$];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default set: empty string, leading and collapsed delimiters, extreme bytes
    push_end();
    push_byte(8'h20); push_byte(8'h00); push_byte(8'hFF);
    push_byte(8'h2C); push_byte(8'h2C); push_end();
    // quoted token holding a delimiter
    push_byte(QUOTE_SINGLE); push_byte(8'h61); push_byte(8'h20);
    push_byte(8'h62); push_byte(QUOTE_SINGLE); push_end();
    // escaped quote leaves the region open until end of string
    push_byte(QUOTE_DOUBLE); push_byte(8'h78); push_byte(BACKSLASH);
    push_byte(QUOTE_DOUBLE); push_end();
    wait_idle();

    // empty set: a bare end gives one empty token
    write_delims('0);
    push_end();
    push_byte(8'h71); push_end();
    wait_idle();

    // quote among the delimiters
    write_delims(32'h0000_2700);
    push_byte(8'h7A); push_end();
    wait_idle();

    // random strings over a spread of settings
    plan = '{DELIM_RESET, 32'hFFFF_FFFF, 32'h0000_0000, 32'h2C00_3B00, 32'h005C_2000,
             32'h2200_0000, 32'h0000_00FF, random_set(), random_set(), DELIM_RESET};
    foreach (plan[i]) begin
      write_delims(plan[i]);
      fill_phase(gen_set);
      wait_idle();
    end

    $display("sent %0d byte requests over %0d delimiter settings", bytes_taken, settings_used);
    $display("checked %0d results, %0d mismatches", results_seen, fault_count);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
